// ===== src/sacb_pkg.sv =====
// Shared types and constants for the set-associative byte cache with bit pseudo-LRU.
package sacb_pkg;

  localparam int MODE_W     = 2;
  localparam int SET_IN_W   = 4;
  localparam int TAG_W      = 24;
  localparam int OFF_IN_W   = 4;
  localparam int BYTE_W     = 8;
  localparam int PAGE_W     = 28;
  localparam int PSHIFT_W   = 5;
  localparam int WAY_OUT_W  = 2;

  localparam logic [PSHIFT_W-1:0] PSHIFT_RESET = 5'd10;

  localparam int SETS_DEF        = 16;
  localparam int WAYS_DEF        = 4;
  localparam int BLOCK_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TOUCH = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_INVAL = 2'd3
  } mode_t;

  // One way of a set as it sits in the tag memory.
  typedef struct packed {
    logic             valid;
    logic             recent;
    logic [TAG_W-1:0] tag;
  } way_entry_t;

endpackage

// ===== src/sacb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module sacb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sacb_lookup.sv =====
// Tag compare, victim choice and MRU-bit update for one set.
module sacb_lookup #(
  parameter int WAYS  = 4,
  parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  sacb_pkg::way_entry_t [WAYS-1:0] set_word,
  input  logic [sacb_pkg::TAG_W-1:0]      tag,
  output logic                            hit,
  output logic [WAY_W-1:0]                hit_way,
  output logic [WAY_W-1:0]                touch_way,
  output sacb_pkg::way_entry_t [WAYS-1:0] touch_word
);
  import sacb_pkg::*;

  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic             clr_found;
  logic [WAY_W-1:0] clr_way;
  logic [WAY_W-1:0] victim;
  logic             all_recent;
  way_entry_t [WAYS-1:0] upd;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    clr_found = 1'b0;
    clr_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && set_word[w].valid && (set_word[w].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!inv_found && !set_word[w].valid) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (!clr_found && !set_word[w].recent) begin
        clr_found = 1'b1;
        clr_way   = WAY_W'(w);
      end
    end

    // Lowest invalid way first, then lowest way not recently used, else way 0.
    if (inv_found) begin
      victim = inv_way;
    end else if (clr_found) begin
      victim = clr_way;
    end else begin
      victim = '0;
    end
    touch_way = hit ? hit_way : victim;

    upd = set_word;
    if (!hit) begin
      upd[touch_way].valid = 1'b1;
      upd[touch_way].tag   = tag;
    end
    upd[touch_way].recent = 1'b1;

    // When the whole set is valid and recent, only the touched way keeps its bit.
    all_recent = 1'b1;
    for (int w = 0; w < WAYS; w++) begin
      all_recent = all_recent & upd[w].valid & upd[w].recent;
    end
    if (all_recent) begin
      for (int w = 0; w < WAYS; w++) begin
        upd[w].recent = (WAY_W'(w) == touch_way);
      end
    end
    touch_word = upd;
  end

endmodule

// ===== src/sacb_inval.sv =====
// Page match and clear of one set during an invalidate sweep.
module sacb_inval #(
  parameter int WAYS        = 4,
  parameter int SETS        = 16,
  parameter int BLOCK_BYTES = 16,
  parameter int ADDR_BITS   = 32
) (
  input  sacb_pkg::way_entry_t [WAYS-1:0] set_word,
  input  logic [ADDR_BITS-1:0]            set_base,
  input  logic [ADDR_BITS-1:0]            addr_mask,
  input  logic [ADDR_BITS-1:0]            page_lo,
  input  logic                            page_ok,
  output sacb_pkg::way_entry_t [WAYS-1:0] cleared_word
);
  import sacb_pkg::*;

  // Bytes covered by one tag step: the whole index space of the cache.
  localparam logic [ADDR_BITS-1:0] TAG_SPAN = ADDR_BITS'(SETS * BLOCK_BYTES);

  logic [WAYS-1:0][ADDR_BITS-1:0] line_addr;
  logic [WAYS-1:0]                match;

  always_comb begin
    cleared_word = set_word;
    for (int w = 0; w < WAYS; w++) begin
      line_addr[w] = ADDR_BITS'(set_word[w].tag) * TAG_SPAN + set_base;
      match[w]     = page_ok && ((line_addr[w] & addr_mask) == page_lo);
      if (match[w]) begin
        cleared_word[w].valid  = 1'b0;
        cleared_word[w].recent = 1'b0;
      end
    end
  end

endmodule

// ===== src/set_assoc_cache_bit_plru_top.sv =====
// Top level of the set-associative byte cache with bit pseudo-LRU replacement.
//
// The cache keeps SETS sets of WAYS ways. Valid bit, MRU bit and 24-bit tag of all ways
// of a set share one word of a tag memory; line bytes sit in a separate byte-wide data
// memory. Both memories have a registered read. A request is taken only while the
// control sequencer is idle, so one request is in flight at a time; a finished response
// sits in the output register while the next request is accepted. A touch runs a tag
// read, then compare and tag write-back; a write runs a tag read, then compare and, on a
// hit, byte write; a read that hits runs a tag read, a data read and data out, and a read
// miss ends at the compare. A page invalidate reads and writes back every set in turn.
// After reset the sequencer runs a clearing pass over every set of the tag memory, during
// which no request is accepted; configuration writes are taken at any time. The data of a
// line that was just installed by a touch is not defined until each byte read has first
// been written. Set index and byte offset wrap modulo SETS and BLOCK_BYTES. Because the tag
// write-back completes before the next request is accepted, back-to-back requests to the
// same set always see the updated word and need no forwarding.
module set_assoc_cache_bit_plru_top #(
  parameter int SETS        = sacb_pkg::SETS_DEF,
  parameter int WAYS        = sacb_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sacb_pkg::BLOCK_BYTES_DEF,
  parameter int ADDR_BITS   = sacb_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [sacb_pkg::PSHIFT_W-1:0]   cfg_write_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [sacb_pkg::MODE_W-1:0]     mode,
  input  logic [sacb_pkg::SET_IN_W-1:0]   set_index,
  input  logic [sacb_pkg::TAG_W-1:0]      tag,
  input  logic [sacb_pkg::OFF_IN_W-1:0]   byte_offset,
  input  logic [sacb_pkg::BYTE_W-1:0]     write_data,
  input  logic [sacb_pkg::PAGE_W-1:0]     page_number,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            hit,
  output logic [sacb_pkg::WAY_OUT_W-1:0]  way,
  output logic [sacb_pkg::BYTE_W-1:0]     read_data
);
  import sacb_pkg::*;

  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WX_W       = WAY_W + WAY_OUT_W;
  localparam int OFF_W      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int DATA_DEPTH = SETS * WAYS * BLOCK_BYTES;
  localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int TWORD_W    = $bits(way_entry_t) * WAYS;
  localparam int PB_W       = PAGE_W + (1 << PSHIFT_W) - 1;
  localparam int IN_CODES   = 1 << SET_IN_W;
  localparam int OFF_CODES  = 1 << OFF_IN_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  typedef logic [IN_CODES-1:0][SET_W-1:0]  set_lut_t;
  typedef logic [OFF_CODES-1:0][OFF_W-1:0] off_lut_t;

  // Wrap tables for the narrow index fields, built at elaboration.
  function automatic set_lut_t build_set_lut();
    set_lut_t t;
    for (int i = 0; i < IN_CODES; i++) begin
      t[i] = SET_W'(i % SETS);
    end
    return t;
  endfunction

  function automatic off_lut_t build_off_lut();
    off_lut_t t;
    for (int i = 0; i < OFF_CODES; i++) begin
      t[i] = OFF_W'(i % BLOCK_BYTES);
    end
    return t;
  endfunction

  localparam set_lut_t SET_LUT = build_set_lut();
  localparam off_lut_t OFF_LUT = build_off_lut();

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_READ   = 6'b001000,
    S_SWEEP  = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  state_t state;

  logic [PSHIFT_W-1:0] page_shift;

  // Captured request.
  mode_t             req_mode;
  logic [SET_W-1:0]  req_set;
  logic [TAG_W-1:0]  req_tag;
  logic [OFF_W-1:0]  req_off;
  logic [BYTE_W-1:0] req_wdata;

  // Sweep control; set counter and last-set flag are shared by the reset clearing pass and page invalidation.
  logic [SET_W-1:0]     sweep_set;
  logic [ADDR_BITS-1:0] set_base;
  logic [ADDR_BITS-1:0] inv_mask;
  logic [ADDR_BITS-1:0] inv_lo;
  logic                 inv_ok;
  logic                 sweep_last;

  // Response held while the output register is still occupied.
  logic                 res_hit;
  logic [WAY_OUT_W-1:0] res_way;
  logic [BYTE_W-1:0]    res_data;
  logic [WAY_W-1:0]     read_way;

  logic             accept;
  logic             out_free;
  mode_t            in_mode;
  logic [PB_W-1:0]  page_base;

  logic                   tag_we;
  logic [SET_W-1:0]       tag_waddr;
  logic [TWORD_W-1:0]     tag_wdata;
  logic                   tag_re;
  logic [SET_W-1:0]       tag_raddr;
  logic [TWORD_W-1:0]     tag_rdata;
  way_entry_t [WAYS-1:0]  set_word;

  logic                   lk_hit;
  logic [WAY_W-1:0]       lk_hit_way;
  logic [WAY_W-1:0]       lk_touch_way;
  way_entry_t [WAYS-1:0]  lk_touch_word;
  way_entry_t [WAYS-1:0]  inv_word;

  logic                 data_we;
  logic                 data_re;
  logic [DATA_AW-1:0]   data_addr;
  logic [BYTE_W-1:0]    data_rdata;

  logic                 fin;
  logic                 fin_hit;
  logic [WAY_OUT_W-1:0] fin_way;
  logic [BYTE_W-1:0]    fin_data;
  logic [WX_W-1:0]      hit_way_x;
  logic [WX_W-1:0]      touch_way_x;
  logic [WX_W-1:0]      read_way_x;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign in_mode    = mode_t'(mode);
  assign sweep_last = (sweep_set == LAST_SET);
  assign set_word   = tag_rdata;

  // Page base address; bits above the address width must be zero for any line to match.
  assign page_base = PB_W'(page_number) << page_shift;

  assign hit_way_x   = WX_W'(lk_hit_way);
  assign touch_way_x = WX_W'(lk_touch_way);
  assign read_way_x  = WX_W'(read_way);

  sacb_ram #(
    .WIDTH (TWORD_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  sacb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DATA_DEPTH),
    .AW    (DATA_AW)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_addr),
    .wdata (req_wdata),
    .re    (data_re),
    .raddr (data_addr),
    .rdata (data_rdata)
  );

  sacb_lookup #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_lookup (
    .set_word   (set_word),
    .tag        (req_tag),
    .hit        (lk_hit),
    .hit_way    (lk_hit_way),
    .touch_way  (lk_touch_way),
    .touch_word (lk_touch_word)
  );

  sacb_inval #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_inval (
    .set_word     (set_word),
    .set_base     (set_base),
    .addr_mask    (inv_mask),
    .page_lo      (inv_lo),
    .page_ok      (inv_ok),
    .cleared_word (inv_word)
  );

  // Memory port control.
  always_comb begin
    tag_re    = 1'b0;
    tag_raddr = SET_LUT[set_index];
    tag_we    = 1'b0;
    tag_waddr = req_set;
    tag_wdata = lk_touch_word;
    case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = sweep_set;
        tag_wdata = '0;
      end
      S_IDLE: begin
        tag_re = accept;
        if (in_mode == MODE_INVAL) begin
          tag_raddr = '0;
        end
      end
      S_LOOKUP: begin
        tag_we = (req_mode == MODE_TOUCH);
      end
      S_SWEEP: begin
        tag_we    = 1'b1;
        tag_waddr = sweep_set;
        tag_wdata = inv_word;
        tag_re    = !sweep_last;
        tag_raddr = sweep_set + SET_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Byte address of the hitting way's line.
  assign data_addr = DATA_AW'(req_set) * DATA_AW'(WAYS * BLOCK_BYTES)
                   + DATA_AW'(lk_hit_way) * DATA_AW'(BLOCK_BYTES)
                   + DATA_AW'(req_off);
  assign data_we   = (state == S_LOOKUP) && (req_mode == MODE_WRITE) && lk_hit;
  assign data_re   = (state == S_LOOKUP) && (req_mode == MODE_READ) && lk_hit;

  // Response produced when a request completes, or replayed from the hold registers.
  always_comb begin
    fin      = 1'b0;
    fin_hit  = 1'b0;
    fin_way  = '0;
    fin_data = '0;
    case (state)
      S_LOOKUP: begin
        case (req_mode)
          MODE_TOUCH: begin
            fin     = 1'b1;
            fin_hit = lk_hit;
            fin_way = touch_way_x[WAY_OUT_W-1:0];
          end
          MODE_WRITE: begin
            fin     = 1'b1;
            fin_hit = lk_hit;
            fin_way = lk_hit ? hit_way_x[WAY_OUT_W-1:0] : '0;
          end
          MODE_READ: begin
            fin = !lk_hit;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        fin      = 1'b1;
        fin_hit  = 1'b1;
        fin_way  = read_way_x[WAY_OUT_W-1:0];
        fin_data = data_rdata;
      end
      S_SWEEP: begin
        fin = sweep_last;
      end
      S_HOLD: begin
        fin      = 1'b1;
        fin_hit  = res_hit;
        fin_way  = res_way;
        fin_data = res_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep_set  <= '0;
      rsp_valid  <= 1'b0;
      page_shift <= PSHIFT_RESET;
    end else begin
      if (cfg_write_en) begin
        page_shift <= cfg_write_data;
      end

      if (rsp_valid && !rsp_stall && !(fin && out_free)) begin
        rsp_valid <= 1'b0;
      end

      if (fin) begin
        if (out_free) begin
          rsp_valid <= 1'b1;
          hit       <= fin_hit;
          way       <= fin_way;
          read_data <= fin_data;
          state     <= S_IDLE;
        end else begin
          res_hit  <= fin_hit;
          res_way  <= fin_way;
          res_data <= fin_data;
          state    <= S_HOLD;
        end
      end

      case (state)
        S_CLEAR: begin
          sweep_set <= sweep_set + SET_W'(1);
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_mode  <= in_mode;
            req_set   <= SET_LUT[set_index];
            req_tag   <= tag;
            req_off   <= OFF_LUT[byte_offset];
            req_wdata <= write_data;
            if (in_mode == MODE_INVAL) begin
              state     <= S_SWEEP;
              sweep_set <= '0;
              set_base  <= '0;
              inv_mask  <= {ADDR_BITS{1'b1}} << page_shift;
              inv_lo    <= page_base[ADDR_BITS-1:0];
              inv_ok    <= (page_base[PB_W-1:ADDR_BITS] == '0);
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          if ((req_mode == MODE_READ) && lk_hit) begin
            state    <= S_READ;
            read_way <= lk_hit_way;
          end
        end
        S_SWEEP: begin
          if (!sweep_last) begin
            sweep_set <= sweep_set + SET_W'(1);
            set_base  <= set_base + ADDR_BITS'(BLOCK_BYTES);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A lookup request always goes to the tag compare in the next cycle.
  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_mode != MODE_INVAL)) |=> (state == S_LOOKUP))
    else $error("accepted request did not reach tag compare");

  // The hold state is only entered while the output register is occupied.
  a_hold_has_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> rsp_valid)
    else $error("response held while output register is empty");

  // A reported hit really matches a valid way of the set.
  a_hit_matches: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOOKUP) && lk_hit) |->
      (set_word[lk_hit_way].valid && (set_word[lk_hit_way].tag == req_tag)))
    else $error("hit way does not match the request tag");

  // The last set of a sweep leads in the next cycle to a response or to the hold state.
  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP) && sweep_last) |=> (rsp_valid || (state == S_HOLD)))
    else $error("invalidate sweep ended without a response");

  // The tag memory is never read and written at the same set during a sweep.
  a_sweep_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP) && tag_re) |-> (tag_raddr != tag_waddr))
    else $error("sweep read and write-back hit the same set");

endmodule

// ===== sim/set_assoc_cache_bit_plru_top_tb.sv =====
// Self-checking testbench for the set-associative byte cache with bit pseudo-LRU.
module set_assoc_cache_bit_plru_top_tb;
  import sacb_pkg::*;

  // The testbench keeps two independent copies of the cache contents. The
  // stimulus copy is advanced while requests are generated, so the generator
  // knows which lines hit and which bytes were written since their install.
  // The scoreboard copy is advanced only when the DUT accepts a request, and
  // it produces the response that is expected back.
  localparam int STIM_COPY  = 0;
  localparam int SCORE_COPY = 1;
  localparam int LINES      = SETS_DEF * WAYS_DEF;
  localparam int BYTES      = LINES * BLOCK_BYTES_DEF;

  // Longest stretch without any accepted request or response before the run
  // is declared hung. The slowest legal stretches are the clearing pass after
  // reset, a page sweep, a sender gap and a receiver stall run.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles at the end, to catch a late or duplicated response.
  localparam int TAIL_CYCLES    = 24;
  localparam int PHASES         = 7;
  localparam int PHASE_REQS     = 205;

  typedef struct packed {
    mode_t                 mode;
    logic [SET_IN_W-1:0]   set_index;
    logic [TAG_W-1:0]      tag;
    logic [OFF_IN_W-1:0]   byte_offset;
    logic [BYTE_W-1:0]     write_data;
    logic [PAGE_W-1:0]     page_number;
  } cache_req_t;

  typedef struct packed {
    logic                  hit;
    logic [WAY_OUT_W-1:0]  way;
    logic [BYTE_W-1:0]     read_data;
  } cache_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [PSHIFT_W-1:0]   cfg_write_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [MODE_W-1:0]     mode = '0;
  logic [SET_IN_W-1:0]   set_index = '0;
  logic [TAG_W-1:0]      tag = '0;
  logic [OFF_IN_W-1:0]   byte_offset = '0;
  logic [BYTE_W-1:0]     write_data = '0;
  logic [PAGE_W-1:0]     page_number = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way;
  logic [BYTE_W-1:0]     read_data;

  // Cache contents, one row per copy.
  bit                    line_valid   [2][LINES];
  bit [TAG_W-1:0]        line_tag     [2][LINES];
  bit                    line_mru     [2][LINES];
  bit [BYTE_W-1:0]       line_byte    [2][BYTES];
  bit                    byte_written [2][BYTES];
  logic [PSHIFT_W-1:0]   page_shift_q [2];

  cache_req_t            pending_req[$];
  cache_rsp_t            expected_rsp[$];
  cache_req_t            held_req;
  bit [TAG_W-1:0]        tag_pool [8];

  int                    mismatches = 0;
  int                    idle_cycles = 0;
  int                    burst_left = 0;
  int                    gap_left = 0;
  int                    stall_style = 0;
  int                    style_left = 0;
  int                    run_left = 0;
  bit                    run_stalled = 1'b0;
  logic [7:0]            stall_pattern = 8'h00;

  set_assoc_cache_bit_plru_top DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .mode           (mode),
    .set_index      (set_index),
    .tag            (tag),
    .byte_offset    (byte_offset),
    .write_data     (write_data),
    .page_number    (page_number),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .hit            (hit),
    .way            (way),
    .read_data      (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Returns the way of the set that holds the tag, or -1 when it misses.
  function automatic int find_way(int cp, int set_no, logic [TAG_W-1:0] t);
    int hw;
    int w;
    hw = -1;
    for (w = 0; w < WAYS_DEF; w++) begin
      if (hw < 0 && line_valid[cp][set_no * WAYS_DEF + w] &&
          line_tag[cp][set_no * WAYS_DEF + w] == t) begin
        hw = w;
      end
    end
    return hw;
  endfunction

  // Page number of a line: its byte address, (tag*SETS+set)*BLOCK_BYTES,
  // is exactly 32 bits wide here, shifted down by the page size.
  function automatic logic [31:0] line_page(int cp, int ln);
    logic [31:0]         byte_addr;
    logic [SET_IN_W-1:0] set_no;
    set_no = SET_IN_W'(ln / WAYS_DEF);
    byte_addr = {line_tag[cp][ln], set_no, 4'b0000};
    return byte_addr >> page_shift_q[cp];
  endfunction

  // Applies one request to a copy of the cache and returns its response.
  function automatic cache_rsp_t cache_step(int cp, cache_req_t r);
    cache_rsp_t res;
    int         base;
    int         hw;
    int         sel;
    int         clear_w;
    int         ln;
    int         w;
    int         b;
    bit         all_mru;
    res = '0;
    base = int'(r.set_index) * WAYS_DEF;
    hw = find_way(cp, int'(r.set_index), r.tag);
    case (r.mode)
      MODE_TOUCH: begin
        if (hw >= 0) begin
          res.hit = 1'b1;
          sel = hw;
        end else begin
          // Victim: first invalid way, else first way whose MRU bit is
          // clear, else way 0. The new line starts with unknown bytes.
          sel = -1;
          clear_w = -1;
          for (w = 0; w < WAYS_DEF; w++) begin
            if (!line_valid[cp][base + w]) begin
              if (sel < 0) sel = w;
            end else if (!line_mru[cp][base + w] && clear_w < 0) begin
              clear_w = w;
            end
          end
          if (sel < 0) sel = (clear_w < 0) ? 0 : clear_w;
          ln = base + sel;
          line_valid[cp][ln] = 1'b1;
          line_tag[cp][ln] = r.tag;
          for (b = 0; b < BLOCK_BYTES_DEF; b++) begin
            line_byte[cp][ln * BLOCK_BYTES_DEF + b] = '0;
            byte_written[cp][ln * BLOCK_BYTES_DEF + b] = 1'b0;
          end
        end
        res.way = WAY_OUT_W'(sel);
        // Once every way is valid and MRU, only the touched way keeps its bit.
        line_mru[cp][base + sel] = 1'b1;
        all_mru = 1'b1;
        for (w = 0; w < WAYS_DEF; w++) begin
          if (!line_valid[cp][base + w] || !line_mru[cp][base + w]) all_mru = 1'b0;
        end
        if (all_mru) begin
          for (w = 0; w < WAYS_DEF; w++) line_mru[cp][base + w] = (w == sel);
        end
      end
      MODE_READ: begin
        if (hw >= 0) begin
          res.hit = 1'b1;
          res.way = WAY_OUT_W'(hw);
          res.read_data = line_byte[cp][(base + hw) * BLOCK_BYTES_DEF + int'(r.byte_offset)];
        end
      end
      MODE_WRITE: begin
        if (hw >= 0) begin
          res.hit = 1'b1;
          res.way = WAY_OUT_W'(hw);
          line_byte[cp][(base + hw) * BLOCK_BYTES_DEF + int'(r.byte_offset)] = r.write_data;
          byte_written[cp][(base + hw) * BLOCK_BYTES_DEF + int'(r.byte_offset)] = 1'b1;
        end
      end
      MODE_INVAL: begin
        // Every line is checked, invalid ones too; a cleared line also
        // loses its MRU bit.
        for (ln = 0; ln < LINES; ln++) begin
          if (line_page(cp, ln) == 32'(r.page_number)) begin
            line_valid[cp][ln] = 1'b0;
            line_mru[cp][ln] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic cache_req_t mk_req(mode_t m, int s, logic [TAG_W-1:0] t, int off,
                                        logic [BYTE_W-1:0] d, logic [PAGE_W-1:0] pg);
    cache_req_t r;
    r.mode = m;
    r.set_index = SET_IN_W'(s);
    r.tag = t;
    r.byte_offset = OFF_IN_W'(off);
    r.write_data = d;
    r.page_number = pg;
    return r;
  endfunction

  // Queues a request for the driver. A read that would hit a byte not yet
  // written since its line was installed has no defined answer, so it is
  // moved to a written byte of the same line, or turned into a write.
  function automatic void queue_item(cache_req_t r);
    int hw;
    int line_base;
    int start;
    int o;
    int found_off;
    if (r.mode == MODE_READ) begin
      hw = find_way(STIM_COPY, int'(r.set_index), r.tag);
      if (hw >= 0) begin
        line_base = (int'(r.set_index) * WAYS_DEF + hw) * BLOCK_BYTES_DEF;
        if (!byte_written[STIM_COPY][line_base + int'(r.byte_offset)]) begin
          found_off = -1;
          start = $urandom_range(0, BLOCK_BYTES_DEF - 1);
          for (o = 0; o < BLOCK_BYTES_DEF; o++) begin
            if (found_off < 0 &&
                byte_written[STIM_COPY][line_base + (start + o) % BLOCK_BYTES_DEF]) begin
              found_off = (start + o) % BLOCK_BYTES_DEF;
            end
          end
          if (found_off >= 0) r.byte_offset = OFF_IN_W'(found_off);
          else r.mode = MODE_WRITE;
        end
      end
    end
    void'(cache_step(STIM_COPY, r));
    pending_req.push_back(r);
  endfunction

  // One random request. Tags mostly come from a small pool so that sets
  // fill up, lines get evicted and reads find data; page invalidates mostly
  // name the page of a line that is resident right now.
  function automatic cache_req_t random_req();
    cache_req_t  r;
    int          pick;
    int          ln;
    logic [31:0] pg;
    r.set_index = SET_IN_W'($urandom);
    r.byte_offset = OFF_IN_W'($urandom);
    r.write_data = BYTE_W'($urandom);
    r.page_number = PAGE_W'($urandom);
    r.tag = ($urandom_range(0, 9) == 0) ? TAG_W'($urandom) : tag_pool[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 28) r.mode = MODE_TOUCH;
    else if (pick < 55) r.mode = MODE_WRITE;
    else if (pick < 92) r.mode = MODE_READ;
    else r.mode = MODE_INVAL;
    if (r.mode == MODE_INVAL && $urandom_range(0, 9) < 7) begin
      ln = $urandom_range(0, LINES - 1);
      if (line_valid[STIM_COPY][ln]) begin
        pg = line_page(STIM_COPY, ln);
        r.page_number = pg[PAGE_W-1:0];
      end
    end
    return r;
  endfunction

  // Most of the random traffic is line-sized stories: install a line, write
  // some of its bytes, read some back. The rest is single random requests.
  task automatic queue_random_phase(int count);
    int         made;
    int         n;
    cache_req_t r;
    made = 0;
    while (made < count) begin
      r = random_req();
      if ($urandom_range(0, 99) < 45) begin
        r.mode = MODE_TOUCH;
        queue_item(r);
        made++;
        n = $urandom_range(1, 4);
        repeat (n) begin
          r.mode = MODE_WRITE;
          r.byte_offset = OFF_IN_W'($urandom);
          r.write_data = BYTE_W'($urandom);
          queue_item(r);
          made++;
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          r.mode = MODE_READ;
          r.byte_offset = OFF_IN_W'($urandom);
          queue_item(r);
          made++;
        end
      end else begin
        queue_item(r);
        made++;
      end
    end
  endtask

  // Waits until every queued request was taken and answered.
  task automatic drain();
    do @(negedge clk);
    while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
  endtask

  // Only called while the cache is idle, so both copies can follow at once.
  task automatic set_page_shift(logic [PSHIFT_W-1:0] v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    page_shift_q[STIM_COPY] = v;
    page_shift_q[SCORE_COPY] = v;
  endtask

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Request driver. The scoreboard copy is advanced on the edge where a
  // request is accepted, which keeps it in the same order as the DUT. A new
  // request is only presented once the previous one has gone, and the sender
  // works in bursts with random gaps, sometimes none at all.
  always @(posedge clk) begin : request_driver
    cache_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsp.push_back(cache_step(SCORE_COPY, held_req));
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_req.size() > 0) begin
          nxt = pending_req.pop_front();
          held_req <= nxt;
          mode <= nxt.mode;
          set_index <= nxt.set_index;
          tag <= nxt.tag;
          byte_offset <= nxt.byte_offset;
          write_data <= nxt.write_data;
          page_number <= nxt.page_number;
          req_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              3:       gap_left = $urandom_range(10, 25);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor, receiver stall pattern and watchdog. The stall style
  // changes at random intervals: never stalling, coin flips, alternating
  // runs of stalled and free cycles, or a rotating bit pattern that always
  // holds at least one free slot.
  always @(posedge clk) begin : response_monitor
    cache_rsp_t want;
    bit         stall_next;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          log_mismatch($sformatf("unexpected response: hit=%0d way=%0d data=%02h",
                                 hit, way, read_data));
        end else begin
          want = expected_rsp.pop_front();
          if (hit !== want.hit || way !== want.way || read_data !== want.read_data) begin
            log_mismatch($sformatf(
              "response mismatch: expected hit=%0d way=%0d data=%02h, got hit=%0d way=%0d data=%02h",
              want.hit, want.way, want.read_data, hit, way, read_data));
          end
        end
      end

      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(40, 300);
        stall_pattern = 8'($urandom) & 8'hFE;
        run_left = 0;
      end else begin
        style_left--;
      end
      case (stall_style)
        0: stall_next = 1'b0;
        1: stall_next = 1'($urandom_range(0, 1));
        2: begin
          if (run_left == 0) begin
            run_stalled = !run_stalled;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          stall_next = run_stalled;
        end
        default: begin
          stall_next = stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
      rsp_stall <= stall_next;

      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                  phase;
    int                  i;
    logic [PSHIFT_W-1:0] next_shift;
    logic [31:0]         pg;
    page_shift_q[STIM_COPY] = PSHIFT_RESET;
    page_shift_q[SCORE_COPY] = PSHIFT_RESET;

    // Directed requests at the reset page size. Set 0 is filled with four
    // tags so that the fourth touch leaves only its own MRU bit, then a new
    // tag must evict the lowest way whose MRU bit is clear.
    queue_item(mk_req(MODE_TOUCH, 0, 24'h000000, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_TOUCH, 0, 24'hFFFFFF, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_TOUCH, 0, 24'h000002, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_TOUCH, 0, 24'h000003, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_TOUCH, 0, 24'h000001, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_TOUCH, 0, 24'hFFFFFF, 0, 8'h00, 28'h0000000));
    // Byte access at both ends of a line, with both extreme data values.
    queue_item(mk_req(MODE_WRITE, 0, 24'hFFFFFF, 0, 8'hFF, 28'h0000000));
    queue_item(mk_req(MODE_WRITE, 0, 24'hFFFFFF, 15, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_READ, 0, 24'hFFFFFF, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_READ, 0, 24'hFFFFFF, 15, 8'h00, 28'h0000000));
    // Read miss and write miss answer all zero and change nothing.
    queue_item(mk_req(MODE_READ, 0, 24'h123456, 3, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_WRITE, 3, 24'hABCDEF, 7, 8'h77, 28'h0000000));
    // The last set.
    queue_item(mk_req(MODE_TOUCH, 15, 24'hABCDEF, 0, 8'h00, 28'hFFFFFFF));
    queue_item(mk_req(MODE_WRITE, 15, 24'hABCDEF, 15, 8'hA5, 28'hFFFFFFF));
    queue_item(mk_req(MODE_READ, 15, 24'hABCDEF, 15, 8'h00, 28'hFFFFFFF));
    queue_item(mk_req(MODE_TOUCH, 15, 24'hABCDEF, 9, 8'h00, 28'hFFFFFFF));
    // Invalidate the page of the line in set 0 way 1; the read then misses.
    pg = line_page(STIM_COPY, 1);
    queue_item(mk_req(MODE_INVAL, 0, 24'h000000, 0, 8'h00, pg[PAGE_W-1:0]));
    queue_item(mk_req(MODE_READ, 0, 24'hFFFFFF, 0, 8'h00, 28'h0000000));
    // Highest and lowest page numbers; page 0 clears the small tags of set 0,
    // so the next install takes the lowest invalid way.
    queue_item(mk_req(MODE_INVAL, 0, 24'h000000, 0, 8'h00, 28'hFFFFFFF));
    queue_item(mk_req(MODE_INVAL, 0, 24'h000000, 0, 8'h00, 28'h0000000));
    queue_item(mk_req(MODE_TOUCH, 0, 24'h000002, 0, 8'h00, 28'h0000000));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Random phases, each at its own page size: both ends of the legal
    // range, both ends of the field, then random values. Between phases the
    // sender holds off until every response has come back.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       next_shift = 5'd4;
        1:       next_shift = 5'd16;
        2:       next_shift = 5'd0;
        3:       next_shift = 5'd31;
        4:       next_shift = PSHIFT_W'($urandom_range(4, 16));
        default: next_shift = PSHIFT_W'($urandom);
      endcase
      set_page_shift(next_shift);
      // The even pool tags among the first six share their upper bits, so larger pages take out
      // several resident lines at once.
      for (i = 0; i < 8; i++) begin
        if (i < 6) tag_pool[i] = {(i % 2 == 0) ? 16'hC35A : 16'($urandom), 8'($urandom)};
        else tag_pool[i] = TAG_W'($urandom);
      end
      queue_random_phase(PHASE_REQS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_rsp.size() != 0) begin
      log_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
